[hw/rtl/y2b_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package y2b_pkg;

    // Coefficient fraction bits (fixed point, floored at the output).
    localparam int COEF_FRAC_BITS = 10;

    // Product width: 10-bit signed offset input times a signed coefficient.
    localparam int COEF_W = COEF_FRAC_BITS + 2;
    localparam int PROD_W = COEF_W + 11;
    // Sum of three products.
    localparam int ACC_W  = PROD_W + 2;

    localparam int K_Y_I  = (1164 * (2 ** COEF_FRAC_BITS) + 500) / 1000;
    localparam int K_BU_I = (2018 * (2 ** COEF_FRAC_BITS) + 500) / 1000;
    localparam int K_GV_I = (813 * (2 ** COEF_FRAC_BITS) + 500) / 1000;
    localparam int K_GU_I = (394 * (2 ** COEF_FRAC_BITS) + 500) / 1000;
    localparam int K_RV_I = (1596 * (2 ** COEF_FRAC_BITS) + 500) / 1000;

    localparam logic signed [PROD_W-1:0] K_Y  = PROD_W'(K_Y_I);
    localparam logic signed [PROD_W-1:0] K_BU = PROD_W'(K_BU_I);
    localparam logic signed [PROD_W-1:0] K_GV = PROD_W'(K_GV_I);
    localparam logic signed [PROD_W-1:0] K_GU = PROD_W'(K_GU_I);
    localparam logic signed [PROD_W-1:0] K_RV = PROD_W'(K_RV_I);

    localparam logic [7:0] KNEE_RESET = 8'd250;

    // Chroma products shared by both pixel lanes.
    typedef struct packed {
        logic signed [PROD_W-1:0] bu;
        logic signed [PROD_W-1:0] gv;
        logic signed [PROD_W-1:0] gu;
        logic signed [PROD_W-1:0] rv;
    } chroma_prod_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } bgr_t;

endpackage

`default_nettype wire

[hw/rtl/y2b_chroma.sv]
`timescale 1ns / 1ps
`default_nettype none

// Shared chroma multipliers, one register stage.
module y2b_chroma
(
    input  wire logic                  clk,
    input  wire logic                  load,
    input  wire logic [7:0]            cb,
    input  wire logic [7:0]            cr,
    output y2b_pkg::chroma_prod_t      prod
);

    logic signed [8:0]                 du;
    logic signed [8:0]                 dv;
    logic signed [y2b_pkg::PROD_W-1:0] du_x;
    logic signed [y2b_pkg::PROD_W-1:0] dv_x;
    y2b_pkg::chroma_prod_t             prod_next;
    y2b_pkg::chroma_prod_t             prod_reg;

    // byte - 128, sign extended
    assign du   = signed'({~cb[7], ~cb[7], cb[6:0]});
    assign dv   = signed'({~cr[7], ~cr[7], cr[6:0]});
    assign du_x = y2b_pkg::PROD_W'(du);
    assign dv_x = y2b_pkg::PROD_W'(dv);

    always_comb
    begin
        prod_next.bu = du_x * y2b_pkg::K_BU;
        prod_next.gv = dv_x * y2b_pkg::K_GV;
        prod_next.gu = du_x * y2b_pkg::K_GU;
        prod_next.rv = dv_x * y2b_pkg::K_RV;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

[hw/rtl/y2b_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

// One pixel lane: luma product (registered), then channel sums and clip.
module y2b_lane
(
    input  wire logic                  clk,
    input  wire logic                  load,
    input  wire logic [7:0]            luma,
    input  wire y2b_pkg::chroma_prod_t chroma,
    input  wire logic [7:0]            clip_knee,
    output y2b_pkg::bgr_t              pix
);

    localparam int F = y2b_pkg::COEF_FRAC_BITS;
    localparam int A = y2b_pkg::ACC_W;

    logic signed [9:0]                 dy;
    logic signed [y2b_pkg::PROD_W-1:0] ly_next;
    logic signed [y2b_pkg::PROD_W-1:0] ly_reg;
    logic signed [A-1:0]               ly_x;
    logic signed [A-1:0]               acc_b;
    logic signed [A-1:0]               acc_g;
    logic signed [A-1:0]               acc_r;
    logic signed [A-1:0]               knee_fix;

    function automatic logic [7:0] clip(input logic signed [A-1:0] acc,
                                        input logic signed [A-1:0] kf);
        logic [7:0] res;
        if (acc[A-1])
            res = 8'd0;
        else if (acc > kf)
            res = 8'd255;
        else
            res = acc[F+7:F];
        return res;
    endfunction

    assign dy      = signed'({2'b00, luma}) - 10'sd16;
    assign ly_next = y2b_pkg::PROD_W'(dy) * y2b_pkg::K_Y;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ly_reg <= ly_next;
        end
    end

    assign ly_x     = A'(ly_reg);
    assign acc_b    = ly_x + A'(chroma.bu);
    assign acc_g    = ly_x - A'(chroma.gv) - A'(chroma.gu);
    assign acc_r    = ly_x + A'(chroma.rv);
    assign knee_fix = signed'(A'({clip_knee, {F{1'b0}}}));

    always_comb
    begin
        pix.blue  = clip(acc_b, knee_fix);
        pix.green = clip(acc_g, knee_fix);
        pix.red   = clip(acc_r, knee_fix);
    end

endmodule

`default_nettype wire

[hw/rtl/yuyv_pair_to_bgr_core.sv]
`timescale 1ns / 1ps
// YUYV pair to BGR (BT.601 video range), two pixel lanes side by side.
// An input word passes the stage 1 and stage 2 registers to its output word.
// Throughput: one word per cycle while the output is not stalled; stage 1
// holds the multipliers, stage 2 the sums, clip and the output register.
// Reset (rst_n, async, active low): pipeline emptied, clip_knee set to 250.
`default_nettype none

module yuyv_pair_to_bgr_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // clip_knee write
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_data,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] first_luma, [15:8] shared_cb, [23:16] second_luma, [31:24] shared_cr
    input  wire logic [31:0] s_axis_tdata,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] first_blue, [15:8] first_green, [23:16] first_red,
    // [31:24] second_blue, [39:32] second_green, [47:40] second_red
    output logic [47:0]      m_axis_tdata
);

    logic                  knee_we;
    logic [7:0]            clip_knee_reg;
    logic                  v1_reg;
    logic                  v2_reg;
    logic                  en1;
    logic                  en2;
    logic                  load1;
    y2b_pkg::chroma_prod_t chroma;
    y2b_pkg::bgr_t         pix0;
    y2b_pkg::bgr_t         pix1;
    logic [47:0]           out_next;
    logic [47:0]           out_reg;

    // stage enables: a stage may take a new word when empty or draining
    assign en2           = !v2_reg || m_axis_tready;
    assign en1           = !v1_reg || en2;
    assign s_axis_tready = en1;
    assign load1         = en1 && s_axis_tvalid;

    assign knee_we = cfg_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_knee_reg <= y2b_pkg::KNEE_RESET;
        end
        else if (knee_we)
        begin
            clip_knee_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // shared Cb/Cr products
    y2b_chroma u_chroma
    (
        .clk  (clk),
        .load (load1),
        .cb   (s_axis_tdata[15:8]),
        .cr   (s_axis_tdata[31:24]),
        .prod (chroma)
    );

    y2b_lane u_lane0
    (
        .clk       (clk),
        .load      (load1),
        .luma      (s_axis_tdata[7:0]),
        .chroma    (chroma),
        .clip_knee (clip_knee_reg),
        .pix       (pix0)
    );

    y2b_lane u_lane1
    (
        .clk       (clk),
        .load      (load1),
        .luma      (s_axis_tdata[23:16]),
        .chroma    (chroma),
        .clip_knee (clip_knee_reg),
        .pix       (pix1)
    );

    // merge: pack both pixels B,G,R into the output word
    assign out_next = {pix1.red, pix1.green, pix1.blue,
                       pix0.red, pix0.green, pix0.blue};

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = v2_reg;
    assign m_axis_tdata  = out_reg;

    // stage 1 never loses a word while stage 2 is blocked
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !en2 |=> v1_reg)
        else $error("stage 1 word dropped under stall");

    // input stalls only when both stages are full and output blocked
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> v1_reg && v2_reg && !m_axis_tready)
        else $error("input stalled without full pipeline");

    // taken output with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !v1_reg |=> !m_axis_tvalid)
        else $error("output word repeated");

    // accepted input always occupies stage 1 next cycle
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> v1_reg)
        else $error("accepted word lost");

endmodule

`default_nettype wire

[verif/yuyv_pair_to_bgr_core_tb.sv]
`timescale 1ns / 1ps
`default_nettype none

module yuyv_pair_to_bgr_core_tb;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 12;
    // A little slack before touching clip_knee or ending.
    localparam int SETTLE_CYCLES    = 4;
    // Watchdog bound, many times the length of a clean run.
    localparam int CYCLE_LIMIT      = 200000;
    localparam int WORDS_PER_PHASE  = 306;
    localparam int IDLE_PERCENT     = 32;

    // BT.601 coefficients, rounded to COEF_FRAC_BITS fraction bits.
    localparam longint FIX_ONE = longint'(1) << y2b_pkg::COEF_FRAC_BITS;
    localparam longint K_LUMA  = (1164 * FIX_ONE + 500) / 1000;
    localparam longint K_B_CB  = (2018 * FIX_ONE + 500) / 1000;
    localparam longint K_G_CR  = (813 * FIX_ONE + 500) / 1000;
    localparam longint K_G_CB  = (394 * FIX_ONE + 500) / 1000;
    localparam longint K_R_CR  = (1596 * FIX_ONE + 500) / 1000;

    localparam longint LUMA_BASE   = 16;
    localparam longint CHROMA_BASE = 128;
    localparam logic [7:0] FULL_SCALE = 8'd255;

    // Input word, first_luma in the low byte.
    typedef struct packed {
        logic [7:0] cr;
        logic [7:0] y1;
        logic [7:0] cb;
        logic [7:0] y0;
    } yuyv_word_t;

    // Output word: first pixel B,G,R in the low 24 bits, second pixel above.
    typedef struct packed {
        y2b_pkg::bgr_t second;
        y2b_pkg::bgr_t first;
    } bgr_word_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [7:0]  cfg_data      = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = 32'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    // Shadow of clip_knee as the core should hold it.
    logic [7:0]  knee_model = y2b_pkg::KNEE_RESET;
    // Gap enables for the input and output side.
    bit          src_gaps   = 1'b1;
    bit          snk_gaps   = 1'b1;
    int          error_count = 0;

    bgr_word_t   bgr_expected_q[$];

    string field_names[6] = '{"first_blue", "first_green", "first_red",
                              "second_blue", "second_green", "second_red"};

    yuyv_pair_to_bgr_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Negative -> 0; strictly above the knee (full fixed-point value) -> 255;
    // otherwise floor. Exactly at the knee is floored, not saturated.
    function automatic logic [7:0] clip_to_byte(longint acc);
        if (acc < 0)
            return 8'd0;
        if (acc > (longint'(knee_model) << y2b_pkg::COEF_FRAC_BITS))
            return FULL_SCALE;
        return acc[y2b_pkg::COEF_FRAC_BITS +: 8];
    endfunction

    function automatic y2b_pkg::bgr_t convert_pixel(logic [7:0] luma, logic [7:0] cb,
                                                    logic [7:0] cr);
        longint        luma_term;
        longint        du;
        longint        dv;
        y2b_pkg::bgr_t px;
        luma_term = K_LUMA * (longint'(luma) - LUMA_BASE);
        du        = longint'(cb) - CHROMA_BASE;
        dv        = longint'(cr) - CHROMA_BASE;
        px.blue   = clip_to_byte(luma_term + K_B_CB * du);
        px.green  = clip_to_byte(luma_term - K_G_CR * dv - K_G_CB * du);
        px.red    = clip_to_byte(luma_term + K_R_CR * dv);
        return px;
    endfunction

    // Both pixels share the chroma pair.
    function automatic bgr_word_t convert_pair(yuyv_word_t w);
        bgr_word_t r;
        r.first  = convert_pixel(w.y0, w.cb, w.cr);
        r.second = convert_pixel(w.y1, w.cb, w.cr);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Output side: random backpressure and the scoreboard check.
    // Values are sampled right after the edge, i.e. pre-edge values.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : out_check
        bgr_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (bgr_expected_q.size() == 0)
            begin
                $error("output word %h with nothing expected", m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = bgr_expected_q.pop_front();
                for (int i = 0; i < 6; i++)
                begin
                    if (m_axis_tdata[8*i +: 8] !== want[8*i +: 8])
                    begin
                        $error("%s: expected %0d, got %0d", field_names[i],
                               want[8*i +: 8], m_axis_tdata[8*i +: 8]);
                        error_count++;
                    end
                end
            end
        end
        m_axis_tready <= !snk_gaps || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("yuyv_pair_to_bgr_core_tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input side helpers
    // ------------------------------------------------------------------

    // Offer one word, optionally after random gaps; predict on accept.
    // tvalid is left high so back-to-back words keep it asserted.
    task automatic send_word(yuyv_word_t w);
        while (src_gaps && ($urandom_range(99) < IDLE_PERCENT))
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bgr_expected_q.push_back(convert_pair(w));
    endtask

    // Stop offering and wait until every expected word came back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (bgr_expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // clip_knee is only written with the pipe empty.
    task automatic write_knee(logic [7:0] knee);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= knee;
        @(posedge clk);
        knee_model = knee;
        cfg_we   <= 1'b0;
    endtask

    function automatic yuyv_word_t pack_word(logic [7:0] y0, logic [7:0] cb,
                                             logic [7:0] y1, logic [7:0] cr);
        yuyv_word_t w;
        w.y0 = y0;
        w.cb = cb;
        w.y1 = y1;
        w.cr = cr;
        return w;
    endfunction

    function automatic logic [7:0] corner_byte();
        case ($urandom_range(5))
            0:       return 8'd0;
            1:       return 8'd16;
            2:       return 8'd128;
            3:       return 8'd235;
            4:       return 8'd240;
            default: return 8'd255;
        endcase
    endfunction

    // Mix of full-range noise, video-range content and corner bytes.
    function automatic yuyv_word_t random_word();
        int unsigned pick;
        yuyv_word_t  w;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            w = $urandom;
        end
        else if (pick < 85)
        begin
            w.y0 = 8'($urandom_range(235, 16));
            w.y1 = 8'($urandom_range(235, 16));
            w.cb = 8'($urandom_range(240, 16));
            w.cr = 8'($urandom_range(240, 16));
        end
        else
        begin
            w.y0 = corner_byte();
            w.cb = corner_byte();
            w.y1 = corner_byte();
            w.cr = corner_byte();
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset knee (250): field extremes, neutral chroma, saturation both ways.
    task automatic test_reset_corners();
        send_word(pack_word(8'd0,   8'd0,   8'd0,   8'd0));
        send_word(pack_word(8'd255, 8'd255, 8'd255, 8'd255));
        send_word(pack_word(8'd16,  8'd128, 8'd235, 8'd128));
        send_word(pack_word(8'd0,   8'd128, 8'd255, 8'd128));
        // strong red / strong blue: one of red and blue saturates high, the other clips to 0
        send_word(pack_word(8'd128, 8'd0,   8'd128, 8'd255));
        send_word(pack_word(8'd128, 8'd255, 8'd128, 8'd0));
        send_word(pack_word(8'd235, 8'd240, 8'd16,  8'd16));
        send_word(pack_word(8'd81,  8'd90,  8'd145, 8'd240));
        send_word(pack_word(8'd255, 8'd0,   8'd0,   8'd255));
    endtask

    // Knee edges. With neutral chroma a luma of 144 lands exactly on 149.0,
    // which must floor to 149; one step more is above the knee.
    task automatic test_knee_edges();
        write_knee(8'd149);
        send_word(pack_word(8'd144, 8'd128, 8'd145, 8'd128));
        send_word(pack_word(8'd143, 8'd128, 8'd144, 8'd128));
        // knee 0: exact zero stays 0, anything positive saturates
        write_knee(8'd0);
        send_word(pack_word(8'd16,  8'd128, 8'd17,  8'd128));
        send_word(pack_word(8'd15,  8'd128, 8'd16,  8'd128));
        // knee 255: values beyond 255 still come out as 255
        write_knee(8'd255);
        send_word(pack_word(8'd255, 8'd128, 8'd255, 8'd128));
        send_word(pack_word(8'd230, 8'd128, 8'd231, 8'd128));
        send_word(pack_word(8'd255, 8'd255, 8'd235, 8'd255));
    endtask

    // Random words in phases, each with its own knee. One phase runs with
    // no gaps on either side; one phase stops mid-way until the pipe drains.
    task automatic test_random_phases();
        logic [7:0] knees[5];
        knees[0] = 8'($urandom_range(255));
        knees[1] = 8'd255;
        knees[2] = 8'($urandom_range(255));
        knees[3] = 8'd0;
        knees[4] = y2b_pkg::KNEE_RESET;
        for (int phase = 0; phase < 5; phase++)
        begin
            write_knee(knees[phase]);
            src_gaps = (phase != 2);
            snk_gaps = (phase != 2);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (phase == 1 && n == WORDS_PER_PHASE / 2)
                    wait_drained();
                send_word(random_word());
            end
        end
        src_gaps = 1'b1;
        snk_gaps = 1'b1;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_corners();
        test_knee_edges();
        test_random_phases();

        wait_drained();
        if (error_count == 0)
            $display("yuyv_pair_to_bgr_core_tb: done, clean");
        else
            $display("yuyv_pair_to_bgr_core_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
hw/rtl/y2b_pkg.sv
hw/rtl/y2b_chroma.sv
hw/rtl/y2b_lane.sv
hw/rtl/yuyv_pair_to_bgr_core.sv
verif/yuyv_pair_to_bgr_core_tb.sv
